@@ src/sblr_pkg.sv @@
// Shared types and constants of the subtract-with-borrow luxury generator.
// No dependencies; used by the top level through scoped names.
`timescale 1ns / 1ps

package sblr_pkg;

  // Data word width and the modulus adjustment (2^32 - 5 as an addend mod 2^32).
  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] MOD_ADJ = 32'hFFFF_FFFB;

  // Luxury level register: field width and largest value.
  localparam int unsigned LUX_W   = 4;
  localparam int unsigned LUX_MAX = 15;
  localparam logic [LUX_W-1:0] LUX_RESET = 4'd1;

  // Configuration register byte addresses.
  localparam logic [1:0] ADDR_LUXURY = 2'd0;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_GEN  = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sblr_state_e;

endpackage

@@ src/sblr_ram.sv @@
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sblr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports; a read during a write to the same entry sees old data.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ src/subtract_borrow_luxury_rng.sv @@
// Top level of the subtract-with-borrow generator with luxury skipping.
// Depends on sblr_pkg and the lag word RAM sblr_ram.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_stall_o    mode_i, seed_word_i
//  out       output     out_valid_o / out_stall_i  random_word_o
//  config    input      APB psel/penable/pwrite    paddr, pwdata, prdata
//
// A load item writes its seed word into the lag RAM at accept. A generate item
// issues N raw steps, where N is 1, or 43 * luxury_level + 1 on every 43rd
// generate item; one raw step issues per cycle through the shared subtract unit,
// limited by the lag RAM's two read ports and one write port, except that the
// final step waits while the output register is still held by a stalled result.
// The lag RAM is not cleared at reset; in_stall_o stays high during a run.

module subtract_borrow_luxury_rng #(
  parameter int unsigned LAG_LONG  = 43,
  parameter int unsigned LAG_SHORT = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] seed_word_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PTR_W  = $clog2(LAG_LONG + 1);
  localparam int unsigned DEPTH  = LAG_LONG + 1;
  localparam int unsigned STEP_W = $clog2(LAG_LONG * sblr_pkg::LUX_MAX + 2);
  localparam int unsigned WW     = sblr_pkg::WORD_W;

  // Architectural state.
  sblr_pkg::sblr_state_e state_q, state_d;
  logic [sblr_pkg::LUX_W-1:0] lux_q;
  logic [PTR_W-1:0]  long_ptr_q, short_ptr_q, phase_q, load_slot_q;
  logic              borrow_q;
  logic [STEP_W-1:0] issue_left_q;

  // Execute stage of the step pipeline.
  logic              ex_valid_q, ex_last_q;
  logic [PTR_W-1:0]  ex_addr_q;
  logic              byp_s_q, byp_l_q;
  logic [WW-1:0]     byp_data_q;

  // Output register.
  logic              out_valid_q;
  logic [WW-1:0]     out_word_q;

  // Control decisions.
  logic              in_acc, out_free, issue, cfg_we;
  logic [PTR_W-1:0]  phase_inc, next_slot;
  logic [STEP_W-1:0] run_steps;

  // RAM ports.
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [WW-1:0]     ram_wdata, rd_s, rd_l;

  // Shared subtract unit.
  logic [WW-1:0]     xs, xl, step_word;
  logic [WW:0]       diff;
  logic              step_neg;
  logic [WW-1:0]     seed_fixed;

  function automatic logic [PTR_W-1:0] dec_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(1)) begin
      r = PTR_W'(LAG_LONG);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

  // Configuration register.
  assign cfg_we = psel && penable && pwrite && (paddr == sblr_pkg::ADDR_LUXURY);
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == sblr_pkg::ADDR_LUXURY) begin
      prdata = {{(32 - sblr_pkg::LUX_W){1'b0}}, lux_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lux_q <= sblr_pkg::LUX_RESET;
    end else if (cfg_we) begin
      lux_q <= pwdata[sblr_pkg::LUX_W-1:0];
    end
  end

  // Input handshake and step count of a generate item.
  assign in_stall_o = (state_q != sblr_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign phase_inc  = phase_q + PTR_W'(1);
  assign run_steps  = (phase_inc == PTR_W'(LAG_LONG))
                    ? STEP_W'(LAG_LONG) * STEP_W'(lux_q) + STEP_W'(1)
                    : STEP_W'(1);
  assign next_slot  = (load_slot_q >= PTR_W'(LAG_LONG)) ? PTR_W'(1)
                                                        : load_slot_q + PTR_W'(1);

  // The final step issues only when the output register will be free.
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: next state and issue decision.
  always_comb begin
    state_d = state_q;
    issue   = 1'b0;
    unique case (state_q)
      sblr_pkg::ST_IDLE: begin
        if (in_acc && mode_i == sblr_pkg::MODE_GEN) begin
          state_d = sblr_pkg::ST_RUN;
        end
      end
      sblr_pkg::ST_RUN: begin
        if (issue_left_q == '0) begin
          state_d = sblr_pkg::ST_IDLE;
        end else begin
          issue = (issue_left_q != STEP_W'(1)) || out_free;
        end
      end
      default: state_d = sblr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sblr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pointers, phase, load slot and remaining step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ptr_q   <= PTR_W'(LAG_LONG);
      short_ptr_q  <= PTR_W'(LAG_SHORT);
      phase_q      <= '0;
      load_slot_q  <= PTR_W'(1);
      issue_left_q <= '0;
    end else if (in_acc && mode_i == sblr_pkg::MODE_LOAD) begin
      long_ptr_q  <= PTR_W'(LAG_LONG);
      short_ptr_q <= PTR_W'(LAG_SHORT);
      phase_q     <= '0;
      load_slot_q <= next_slot;
    end else if (in_acc) begin
      phase_q      <= (phase_inc == PTR_W'(LAG_LONG)) ? '0 : phase_inc;
      issue_left_q <= run_steps;
    end else if (issue) begin
      long_ptr_q   <= dec_ptr(long_ptr_q);
      short_ptr_q  <= dec_ptr(short_ptr_q);
      issue_left_q <= issue_left_q - STEP_W'(1);
    end
  end

  // Execute stage control and bypass capture for a read that meets a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      ex_last_q  <= 1'b0;
    end else begin
      ex_valid_q <= issue;
      ex_last_q  <= issue && (issue_left_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    ex_addr_q  <= long_ptr_q;
    byp_s_q    <= ram_we && (ram_waddr == short_ptr_q);
    byp_l_q    <= ram_we && (ram_waddr == long_ptr_q);
    byp_data_q <= ram_wdata;
  end

  // Shared subtract unit: t = xs - xl - borrow, folded by 2^32 - 5 when negative.
  assign xs        = byp_s_q ? byp_data_q : rd_s;
  assign xl        = byp_l_q ? byp_data_q : rd_l;
  assign diff      = {1'b0, xs} - {1'b0, xl} - {{WW{1'b0}}, borrow_q};
  assign step_neg  = diff[WW];
  assign step_word = step_neg ? diff[WW-1:0] + sblr_pkg::MOD_ADJ : diff[WW-1:0];

  // Borrow: restarted by a load item, updated by every step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b1;
    end else if (in_acc && mode_i == sblr_pkg::MODE_LOAD) begin
      borrow_q <= 1'b1;
    end else if (ex_valid_q) begin
      borrow_q <= step_neg;
    end
  end

  // Seed parity: slot 1 is forced odd and slot 2 even.
  always_comb begin
    seed_fixed = seed_word_i;
    if (load_slot_q == PTR_W'(1)) begin
      seed_fixed[0] = 1'b1;
    end else if (load_slot_q == PTR_W'(2)) begin
      seed_fixed[0] = 1'b0;
    end
  end

  // RAM write: a step result, or a seed word from a load item.
  assign ram_we    = ex_valid_q || (in_acc && mode_i == sblr_pkg::MODE_LOAD);
  assign ram_waddr = ex_valid_q ? ex_addr_q : load_slot_q;
  assign ram_wdata = ex_valid_q ? step_word : seed_fixed;

  sblr_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_lag_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (short_ptr_q),
    .raddr_b_i (long_ptr_q),
    .rdata_a_o (rd_s),
    .rdata_b_o (rd_l)
  );

  // Output register holds the delivered word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_valid_q && ex_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_valid_q && ex_last_q) begin
      out_word_q <= step_word;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

endmodule
